// File: rtl/skt_pkg.sv
// Package for the sorted key table: action and status codes and the
// command and status words between controller and datapath. No dependencies.
package skt_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SORT  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NEXT  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOSORT = 2'd2,
    ST_NOMORE = 2'd3
  } status_e;

  typedef struct packed {
    logic    cap_in;
    logic    set_st;
    status_e st_code;
    logic    load_wr;
    logic    sort_init;
    logic    sort_rd_i;
    logic    sort_take;
    logic    sort_shift;
    logic    sort_place;
    logic    sort_end;
    logic    q_count;
    logic    q_init;
    logic    q_rd;
    logic    q_lo;
    logic    q_hi;
    logic    q_hit;
    logic    n_rd;
    logic    n_skip;
    logic    n_hit;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    full;
    logic    sorted;
    logic    n_le1;
    logic    i_last;
    logic    j_one;
    logic    after;
    logic    lo_lt_hx;
    logic    key_eq;
    logic    key_lt;
    logic    rd_used;
    logic    cur_lt_n;
  } sts_t;

endpackage

// File: rtl/skt_ctrl.sv
// Controller state machine of the sorted key table.
// Depends on skt_pkg for the command and status words.
module skt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  skt_pkg::sts_t sts_i,
  output skt_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_TAKE  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_PLACE = 4'd5;
  localparam logic [3:0] S_QADDR = 4'd6;
  localparam logic [3:0] S_QCMP  = 4'd7;
  localparam logic [3:0] S_NADDR = 4'd8;
  localparam logic [3:0] S_NCHK  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st_code = skt_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.cap_in = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (sts_i.act)
          skt_pkg::ACT_LOAD: begin
            if (sts_i.full) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = skt_pkg::ST_FULL;
            end else begin
              cmd_o.load_wr = 1'b1;
            end
          end
          skt_pkg::ACT_SORT: begin
            if (sts_i.n_le1) begin
              cmd_o.sort_end = 1'b1;
            end else begin
              cmd_o.sort_init = 1'b1;
              state_d = S_RD;
            end
          end
          skt_pkg::ACT_QUERY: begin
            cmd_o.q_count = 1'b1;
            if (!sts_i.sorted) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = skt_pkg::ST_NOSORT;
            end else begin
              cmd_o.q_init = 1'b1;
              state_d = S_QADDR;
            end
          end
          skt_pkg::ACT_NEXT: begin
            if (!sts_i.sorted) begin
              cmd_o.set_st  = 1'b1;
              cmd_o.st_code = skt_pkg::ST_NOSORT;
            end else begin
              state_d = S_NADDR;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RD: begin
        cmd_o.sort_rd_i = 1'b1;
        state_d = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.sort_take = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sts_i.after) begin
          cmd_o.sort_shift = 1'b1;
          if (sts_i.j_one) begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.sort_place = 1'b1;
        if (sts_i.i_last) begin
          cmd_o.sort_end = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_RD;
        end
      end
      S_QADDR: begin
        if (sts_i.lo_lt_hx) begin
          cmd_o.q_rd = 1'b1;
          state_d = S_QCMP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_QCMP: begin
        if (sts_i.key_eq) begin
          cmd_o.q_hit = 1'b1;
          state_d = S_DONE;
        end else begin
          if (sts_i.key_lt) begin
            cmd_o.q_lo = 1'b1;
          end else begin
            cmd_o.q_hi = 1'b1;
          end
          state_d = S_QADDR;
        end
      end
      S_NADDR: begin
        if (sts_i.cur_lt_n) begin
          cmd_o.n_rd = 1'b1;
          state_d = S_NCHK;
        end else begin
          cmd_o.set_st  = 1'b1;
          cmd_o.st_code = skt_pkg::ST_NOMORE;
          state_d = S_DONE;
        end
      end
      S_NCHK: begin
        if (sts_i.rd_used) begin
          cmd_o.n_skip = 1'b1;
          state_d = S_NADDR;
        end else begin
          cmd_o.n_hit = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// File: rtl/skt_dpath.sv
// Datapath of the sorted key table: entry memory, counters, search and sort
// registers and the result registers. Depends on skt_pkg.
module skt_dpath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    action_i,
  input  logic [31:0]   key_i,
  input  skt_pkg::cmd_t cmd_i,
  output skt_pkg::sts_t sts_o,
  output logic [1:0]    status_o,
  output logic          found_o,
  output logic [10:0]   line_number_o,
  output logic [10:0]   unmatched_count_o,
  output logic [31:0]   query_total_o,
  output logic [10:0]   table_count_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = KEY_WIDTH + AW + 1;

  // Memory word: key, load position, used mark.
  logic [MW-1:0] mem_q [TABLE_DEPTH];
  logic [MW-1:0] rdata_q;

  logic [1:0]           act_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [MW-1:0]        tmp_q;
  logic [AW-1:0]        i_q, j_q, mid_q;
  logic [CW-1:0]        lo_q, hx_q;
  logic [CW-1:0]        count_q, unm_q, cur_q;
  logic                 sorted_q;
  logic [31:0]          qcnt_q;
  skt_pkg::status_e     st_q;
  logic                 found_q;
  logic [CW-1:0]        line_q;

  logic [KEY_WIDTH-1:0] rd_key, tmp_key;
  logic [AW-1:0]        rd_pos, tmp_pos;
  logic                 rd_used;
  logic [CW-1:0]        mid_w;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        raddr, waddr;
  logic [MW-1:0]        wdata;

  assign rd_key  = rdata_q[MW-1 -: KEY_WIDTH];
  assign rd_pos  = rdata_q[AW:1];
  assign rd_used = rdata_q[0];
  assign tmp_key = tmp_q[MW-1 -: KEY_WIDTH];
  assign tmp_pos = tmp_q[AW:1];

  assign mid_w = lo_q + ((hx_q - CW'(1) - lo_q) >> 1);

  always_comb begin
    rd_en = 1'b1;
    raddr = '0;
    if (cmd_i.sort_rd_i) begin
      raddr = i_q;
    end else if (cmd_i.sort_take) begin
      raddr = i_q - AW'(1);
    end else if (cmd_i.sort_shift) begin
      raddr = j_q - AW'(2);
    end else if (cmd_i.q_rd) begin
      raddr = mid_w[AW-1:0];
    end else if (cmd_i.n_rd) begin
      raddr = cur_q[AW-1:0];
    end else begin
      rd_en = 1'b0;
    end
  end

  always_comb begin
    wr_en = 1'b1;
    waddr = '0;
    wdata = '0;
    if (cmd_i.load_wr) begin
      waddr = count_q[AW-1:0];
      wdata = {key_q, count_q[AW-1:0], 1'b0};
    end else if (cmd_i.sort_shift) begin
      waddr = j_q;
      wdata = rdata_q;
    end else if (cmd_i.sort_place) begin
      waddr = j_q;
      wdata = tmp_q;
    end else if (cmd_i.q_hit && !rd_used) begin
      waddr = mid_q;
      wdata = {rdata_q[MW-1:1], 1'b1};
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      unm_q    <= '0;
      cur_q    <= '0;
      sorted_q <= 1'b0;
      qcnt_q   <= '0;
    end else begin
      if (cmd_i.load_wr) begin
        count_q  <= count_q + CW'(1);
        unm_q    <= unm_q + CW'(1);
        cur_q    <= '0;
        sorted_q <= 1'b0;
        qcnt_q   <= '0;
      end
      if (cmd_i.sort_end) begin
        sorted_q <= 1'b1;
        cur_q    <= '0;
      end
      if (cmd_i.q_count && qcnt_q != 32'hFFFF_FFFF) begin
        qcnt_q <= qcnt_q + 32'd1;
      end
      if (cmd_i.q_hit && !rd_used && unm_q != '0) begin
        unm_q <= unm_q - CW'(1);
      end
      if (cmd_i.n_skip || cmd_i.n_hit) begin
        cur_q <= cur_q + CW'(1);
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      act_q   <= action_i;
      key_q   <= KEY_WIDTH'(key_i);
      st_q    <= skt_pkg::ST_OK;
      found_q <= 1'b0;
      line_q  <= '0;
    end
    if (cmd_i.set_st) begin
      st_q <= cmd_i.st_code;
    end
    if (cmd_i.sort_init) begin
      i_q <= AW'(1);
    end
    if (cmd_i.sort_take) begin
      tmp_q <= rdata_q;
      j_q   <= i_q;
    end
    if (cmd_i.sort_shift) begin
      j_q <= j_q - AW'(1);
    end
    if (cmd_i.sort_place) begin
      i_q <= i_q + AW'(1);
    end
    if (cmd_i.q_init) begin
      lo_q <= '0;
      hx_q <= count_q;
    end
    if (cmd_i.q_rd) begin
      mid_q <= mid_w[AW-1:0];
    end
    if (cmd_i.q_lo) begin
      lo_q <= CW'(mid_q) + CW'(1);
    end
    if (cmd_i.q_hi) begin
      hx_q <= CW'(mid_q);
    end
    if (cmd_i.q_hit || cmd_i.n_hit) begin
      found_q <= cmd_i.q_hit;
      line_q  <= CW'(rd_pos) + CW'(1);
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.act      = skt_pkg::action_e'(act_q);
    sts_o.full     = (count_q == CW'(TABLE_DEPTH));
    sts_o.sorted   = sorted_q;
    sts_o.n_le1    = (count_q <= CW'(1));
    sts_o.i_last   = ((CW'(i_q) + CW'(1)) == count_q);
    sts_o.j_one    = (j_q == AW'(1));
    sts_o.after    = (rd_key > tmp_key) || ((rd_key == tmp_key) && (rd_pos > tmp_pos));
    sts_o.lo_lt_hx = (lo_q < hx_q);
    sts_o.key_eq   = (rd_key == key_q);
    sts_o.key_lt   = (rd_key < key_q);
    sts_o.rd_used  = rd_used;
    sts_o.cur_lt_n = (cur_q < count_q);
  end

  assign status_o          = st_q;
  assign found_o           = found_q;
  assign line_number_o     = 11'(line_q);
  assign unmatched_count_o = 11'(unm_q);
  assign query_total_o     = qcnt_q;
  assign table_count_o     = 11'(count_q);

endmodule

// File: rtl/sorted_key_table_match_marker.sv
// Top level of the sorted key table: controller and datapath.
// Depends on skt_pkg, skt_ctrl and skt_dpath.
//
// A word is taken when start_i is high and busy_o is low; action_i and key_i
// go with it. Each word yields one result, shown for one cycle with done_o
// high; the receiver cannot stall it. busy_o stays high from the cycle after
// acceptance through the done_o cycle, so the next word may go in right after.
// Every action works through one entry memory with one read and one write
// port and registered read data:
//   load, or a query or next on an unsorted table: decided in the execute state.
//   query: a binary search, each probe a read and then a compare,
//   until a hit or an empty range.
//   next unmatched: the cursor reads entries, skipping used ones, until one is found or none is left.
//   sort: insertion sort; for each entry a read, a take, compares with a shift
//   per shifted entry, and a place.
// Reset clears counts, marks of sortedness, cursor and query total. The
// memory needs no clearing pass: only loaded entries are ever read.
module sorted_key_table_match_marker #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] key_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [10:0] line_number_o,
  output logic [10:0] unmatched_count_o,
  output logic [31:0] query_total_o,
  output logic [10:0] table_count_o
);

  skt_pkg::cmd_t cmd;
  skt_pkg::sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  skt_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .action_i         (action_i),
    .key_i            (key_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .found_o          (found_o),
    .line_number_o    (line_number_o),
    .unmatched_count_o(unmatched_count_o),
    .query_total_o    (query_total_o),
    .table_count_o    (table_count_o)
  );

endmodule

// File: rtl/skt_checker.sv
// Port-level checks of the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table_match_marker.
module skt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  action_i,
  input logic [31:0] key_i,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic        found_o,
  input logic [10:0] line_number_o,
  input logic [10:0] unmatched_count_o,
  input logic [31:0] query_total_o,
  input logic [10:0] table_count_o
);

  // An accepted word keeps the block busy until its result.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o low after accepted word");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done_o outside a busy period");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_found_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> line_number_o != 11'd0 && status_o == skt_pkg::ST_OK)
    else $error("hit without a line number");

  a_nomore_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != skt_pkg::ST_OK |-> line_number_o == 11'd0 && !found_o)
    else $error("line number on a failed word");

endmodule

bind sorted_key_table_match_marker skt_checker u_skt_checker (.*);

// File: verif/sorted_key_table_match_marker_test.sv
// Self-checking testbench for sorted_key_table_match_marker: a directed table of
// words, then random load/sort/query/walk sessions.
// Depends on skt_pkg and the block itself.
module sorted_key_table_match_marker_test;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  status;
    logic        found;
    logic [10:0] line;
    logic [10:0] unmatched;
    logic [31:0] queries;
    logic [10:0] count;
  } answer_t;

  typedef struct {
    skt_pkg::action_e act;
    logic [31:0]      key;
    bit               typed;
    answer_t          ans;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  action_i = skt_pkg::ACT_LOAD;
  logic [31:0] key_i = '0;
  logic        busy_o, done_o, found_o;
  logic [1:0]  status_o;
  logic [10:0] line_number_o, unmatched_count_o, table_count_o;
  logic [31:0] query_total_o;

  sorted_key_table_match_marker uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .key_i, .done_o, .status_o,
    .found_o, .line_number_o, .unmatched_count_o, .query_total_o, .table_count_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [31:0] tbl_key [DEPTH];
  logic [9:0]  tbl_pos [DEPTH];
  bit          tbl_used [DEPTH];
  int unsigned tbl_count, tbl_unmatched, tbl_cursor;
  logic [31:0] tbl_queries;
  bit          tbl_sorted;

  answer_t     pending_answers[$];
  logic [31:0] loaded_keys[$];
  int          idle_pct;
  int          errors;
  int          cycles;

  function automatic answer_t table_apply(skt_pkg::action_e act, logic [31:0] key);
    answer_t r;
    int lo, hi, mid, hit, j;
    logic [31:0] k;
    logic [9:0]  p;
    bit          u;
    r.status = skt_pkg::ST_OK;
    r.found = 1'b0;
    r.line = '0;
    case (act)
      skt_pkg::ACT_LOAD: begin
        if (tbl_count >= DEPTH) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          tbl_key[tbl_count] = key;
          tbl_pos[tbl_count] = tbl_count[9:0];
          tbl_used[tbl_count] = 1'b0;
          tbl_count++;
          tbl_unmatched++;
          tbl_sorted = 1'b0;
          tbl_queries = '0;
          tbl_cursor = 0;
        end
      end
      skt_pkg::ACT_SORT: begin
        for (int i = 1; i < tbl_count; i++) begin
          j = i;
          while (j > 0 && (tbl_key[j-1] > tbl_key[j] ||
                 (tbl_key[j-1] == tbl_key[j] && tbl_pos[j-1] > tbl_pos[j]))) begin
            k = tbl_key[j]; p = tbl_pos[j]; u = tbl_used[j];
            tbl_key[j] = tbl_key[j-1]; tbl_pos[j] = tbl_pos[j-1];
            tbl_used[j] = tbl_used[j-1];
            tbl_key[j-1] = k; tbl_pos[j-1] = p; tbl_used[j-1] = u;
            j--;
          end
        end
        tbl_sorted = 1'b1;
        tbl_cursor = 0;
      end
      skt_pkg::ACT_QUERY: begin
        if (tbl_queries != 32'hFFFF_FFFF) tbl_queries++;
        if (!tbl_sorted) begin
          r.status = skt_pkg::ST_NOSORT;
        end else begin
          lo = 0;
          hi = int'(tbl_count) - 1;
          hit = -1;
          while (lo <= hi && hit < 0) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_key[mid] == key) hit = mid;
            else if (tbl_key[mid] < key) lo = mid + 1;
            else hi = mid - 1;
          end
          if (hit >= 0) begin
            r.found = 1'b1;
            r.line = 11'(tbl_pos[hit]) + 11'd1;
            if (!tbl_used[hit]) begin
              tbl_used[hit] = 1'b1;
              if (tbl_unmatched > 0) tbl_unmatched--;
            end
          end
        end
      end
      default: begin
        if (!tbl_sorted) begin
          r.status = skt_pkg::ST_NOSORT;
        end else begin
          while (tbl_cursor < tbl_count && tbl_used[tbl_cursor]) tbl_cursor++;
          if (tbl_cursor < tbl_count) begin
            r.line = 11'(tbl_pos[tbl_cursor]) + 11'd1;
            tbl_cursor++;
          end else begin
            tbl_cursor = tbl_count;
            r.status = skt_pkg::ST_NOMORE;
          end
        end
      end
    endcase
    r.unmatched = tbl_unmatched[10:0];
    r.queries = tbl_queries;
    r.count = tbl_count[10:0];
    return r;
  endfunction

  // Drives one word from a falling edge and returns at the falling edge after
  // it was taken; start_i stays high so the next word can follow at once.
  task automatic send_word(skt_pkg::action_e act, logic [31:0] key, bit typed = 0,
                           answer_t typed_ans = '{default: '0});
    answer_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    key_i <= key;
    // busy_o only moves on a rising edge, so its value here holds at the next one.
    while (busy_o) @(negedge clk_i);
    predicted = table_apply(act, key);
    pending_answers.push_back(typed ? typed_ans : predicted);
    if (act == skt_pkg::ACT_LOAD) loaded_keys.push_back(key);
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual status %0d line %0d",
                 $time, status_o, line_number_o);
      end else begin
        e = pending_answers.pop_front();
        check_field("status", e.status, status_o);
        check_field("found", e.found, found_o);
        check_field("line_number", e.line, line_number_o);
        check_field("unmatched_count", e.unmatched, unmatched_count_o);
        check_field("query_total", e.queries, query_total_o);
        check_field("table_count", e.count, table_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic row_t row(skt_pkg::action_e act, logic [31:0] key, bit typed = 0,
                               skt_pkg::status_e st = skt_pkg::ST_OK, int un = 0,
                               int qt = 0, int tc = 0);
    row_t r;
    r.act = act;
    r.key = key;
    r.typed = typed;
    r.ans.status = st;
    r.ans.found = 1'b0;
    r.ans.line = '0;
    r.ans.unmatched = 11'(un);
    r.ans.queries = 32'(qt);
    r.ans.count = 11'(tc);
    return r;
  endfunction

  initial begin
    row_t        plan[$];
    logic [31:0] key_pool[8];
    logic [31:0] k;
    int          sent, n;
    errors = 0;
    cycles = 0;
    idle_pct = 29;
    tbl_count = 0; tbl_unmatched = 0; tbl_cursor = 0; tbl_queries = '0; tbl_sorted = 0;
    foreach (tbl_used[i]) tbl_used[i] = 1'b0;

    // Empty table, unsorted and sorted, then duplicates at both key extremes.
    plan.push_back(row(skt_pkg::ACT_QUERY, 32'h0, 1, skt_pkg::ST_NOSORT, 0, 1, 0));
    plan.push_back(row(skt_pkg::ACT_NEXT, 32'h0, 1, skt_pkg::ST_NOSORT, 0, 1, 0));
    plan.push_back(row(skt_pkg::ACT_SORT, 32'h0, 1, skt_pkg::ST_OK, 0, 1, 0));
    plan.push_back(row(skt_pkg::ACT_NEXT, 32'h0, 1, skt_pkg::ST_NOMORE, 0, 1, 0));
    plan.push_back(row(skt_pkg::ACT_QUERY, 32'hFFFF_FFFF, 1, skt_pkg::ST_OK, 0, 2, 0));
    plan.push_back(row(skt_pkg::ACT_LOAD, 32'hFFFF_FFFF, 1, skt_pkg::ST_OK, 1, 0, 1));
    plan.push_back(row(skt_pkg::ACT_LOAD, 32'h0, 1, skt_pkg::ST_OK, 2, 0, 2));
    plan.push_back(row(skt_pkg::ACT_LOAD, 32'hFFFF_FFFF, 1, skt_pkg::ST_OK, 3, 0, 3));
    plan.push_back(row(skt_pkg::ACT_LOAD, 32'h0, 1, skt_pkg::ST_OK, 4, 0, 4));
    plan.push_back(row(skt_pkg::ACT_LOAD, 32'h5555_AAAA, 1, skt_pkg::ST_OK, 5, 0, 5));
    plan.push_back(row(skt_pkg::ACT_QUERY, 32'h0, 1, skt_pkg::ST_NOSORT, 5, 1, 5));
    plan.push_back(row(skt_pkg::ACT_NEXT, 32'h0, 1, skt_pkg::ST_NOSORT, 5, 1, 5));
    plan.push_back(row(skt_pkg::ACT_SORT, 32'h0));
    plan.push_back(row(skt_pkg::ACT_QUERY, 32'hFFFF_FFFF));
    plan.push_back(row(skt_pkg::ACT_QUERY, 32'hFFFF_FFFF));
    plan.push_back(row(skt_pkg::ACT_QUERY, 32'h0));
    plan.push_back(row(skt_pkg::ACT_QUERY, 32'h1234_5678));
    repeat (5) plan.push_back(row(skt_pkg::ACT_NEXT, 32'h0));
    plan.push_back(row(skt_pkg::ACT_SORT, 32'h0));
    plan.push_back(row(skt_pkg::ACT_NEXT, 32'h0));
    plan.push_back(row(skt_pkg::ACT_QUERY, 32'hAAAA_5555));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_word(plan[i].act, plan[i].key, plan[i].typed, plan[i].ans);

    // Random sessions: loads drawn partly from a small pool so keys repeat,
    // a sort, lookups mostly of loaded keys, then a walk over what is left unused.
    foreach (key_pool[i]) key_pool[i] = $urandom;
    sent = 0;
    while (sent < 400) begin
      idle_pct = (sent < 133) ? 29 : (sent < 266) ? 54 : 0;
      n = $urandom_range(1, 10);
      repeat (n) begin
        k = ($urandom_range(1) != 0) ? key_pool[$urandom_range(7)] : $urandom;
        send_word(skt_pkg::ACT_LOAD, k);
        sent++;
      end
      if ($urandom_range(5) == 0) begin
        send_word($urandom_range(1) ? skt_pkg::ACT_QUERY : skt_pkg::ACT_NEXT, $urandom);
        sent++;
      end
      send_word(skt_pkg::ACT_SORT, $urandom);
      sent++;
      n = $urandom_range(1, 10);
      repeat (n) begin
        if ($urandom_range(9) < 7)
          k = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
        else
          k = $urandom;
        send_word(skt_pkg::ACT_QUERY, k);
        sent++;
      end
      n = $urandom_range(1, 6);
      repeat (n) begin
        send_word(skt_pkg::ACT_NEXT, $urandom);
        sent++;
      end
      if ($urandom_range(7) == 0) begin
        send_word(skt_pkg::action_e'($urandom_range(3)), $urandom);
        sent++;
      end
    end
    start_i <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// File: sorted_key_table_match_marker.f
rtl/skt_pkg.sv
rtl/skt_ctrl.sv
rtl/skt_dpath.sv
rtl/sorted_key_table_match_marker.sv
rtl/skt_checker.sv
verif/sorted_key_table_match_marker_test.sv
